>>> src/rsi_pkg.sv
// Shared types, widths and register codes of the ray and slab intersection block.
package rsi_pkg;

    // Default widths of the ray fields
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // Normal and plane offset formats are fixed
    localparam int NORM_WIDTH  = 18;
    localparam int NORM_FRAC   = 16;
    localparam int PLANE_WIDTH = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_NEAR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_FAR  = 3'd4;

    // Slab setup as held in the configuration registers
    typedef struct packed {
        logic signed [NORM_WIDTH-1:0]  nx;
        logic signed [NORM_WIDTH-1:0]  ny;
        logic signed [NORM_WIDTH-1:0]  nz;
        logic signed [PLANE_WIDTH-1:0] near_ofs;
        logic signed [PLANE_WIDTH-1:0] far_ofs;
    } cfg_t;

    // Per-ray control flags that travel down the divider chain
    typedef struct packed {
        logic valid;
        logic parallel;
        logic neg_a;
        logic neg_b;
        logic ovf_a;
        logic ovf_b;
    } ctl_t;

endpackage

>>> src/rsi_front.sv
// Dot products, plane numerators, magnitudes and overflow check ahead of the divider chain.
module rsi_front #(
    parameter int CW   = rsi_pkg::COORD_WIDTH_DEF,
    parameter int F    = rsi_pkg::FRAC_BITS_DEF,
    parameter int DOTW = CW + rsi_pkg::NORM_WIDTH + 2,
    parameter int NUMW = DOTW + 1,
    parameter int W    = NUMW + F
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic signed [CW-1:0]   tl_i,
    input  logic signed [CW-1:0]   ox_i,
    input  logic signed [CW-1:0]   oy_i,
    input  logic signed [CW-1:0]   oz_i,
    input  logic signed [CW-1:0]   dx_i,
    input  logic signed [CW-1:0]   dy_i,
    input  logic signed [CW-1:0]   dz_i,
    input  rsi_pkg::cfg_t          cfg_i,
    output rsi_pkg::ctl_t          ctl_o,
    output logic signed [CW-1:0]   tl_o,
    output logic [DOTW-1:0]        den_o,
    output logic [W-1:0]           rem_a_o,
    output logic [W-1:0]           rem_b_o
);

    localparam int PW = CW + rsi_pkg::NORM_WIDTH;

    // Stage 1: products
    logic                 v1_reg;
    logic signed [CW-1:0] tl1_reg;
    logic signed [PW-1:0] pdx_reg, pdy_reg, pdz_reg, pox_reg, poy_reg, poz_reg;

    // Stage 2: dot products and numerators
    logic                   v2_reg;
    logic signed [CW-1:0]   tl2_reg;
    logic signed [DOTW-1:0] dn2_reg;
    logic signed [NUMW-1:0] na2_reg, nb2_reg;
    logic signed [DOTW-1:0] dn_next, on_next;
    logic signed [NUMW-1:0] na_next, nb_next;

    // Stage 3: magnitudes and signs
    logic                 v3_reg, par3_reg, nega3_reg, negb3_reg;
    logic signed [CW-1:0] tl3_reg;
    logic [DOTW-1:0]      dmag3_reg;
    logic [NUMW-1:0]      amag3_reg, bmag3_reg;

    // Stage 4: scaled remainders and overflow flags
    rsi_pkg::ctl_t        ctl4_reg, ctl4_next;
    logic signed [CW-1:0] tl4_reg;
    logic [DOTW-1:0]      den4_reg;
    logic [W-1:0]         rema4_reg, remb4_reg, rema_next, remb_next, dtop;

    // Form both dot products and the two plane numerators
    always_comb begin
        dn_next = DOTW'(pdx_reg) + DOTW'(pdy_reg) + DOTW'(pdz_reg);
        on_next = DOTW'(pox_reg) + DOTW'(poy_reg) + DOTW'(poz_reg);
        na_next = (NUMW'(cfg_i.near_ofs) <<< rsi_pkg::NORM_FRAC) - NUMW'(on_next);
        nb_next = (NUMW'(cfg_i.far_ofs) <<< rsi_pkg::NORM_FRAC) - NUMW'(on_next);
    end

    // Scale numerators by the fraction bits and test for a quotient past the top bit
    always_comb begin
        rema_next = W'(amag3_reg) << F;
        remb_next = W'(bmag3_reg) << F;
        dtop      = W'(dmag3_reg) << (CW - 1);
        ctl4_next.valid    = v3_reg;
        ctl4_next.parallel = par3_reg;
        ctl4_next.neg_a    = nega3_reg;
        ctl4_next.neg_b    = negb3_reg;
        ctl4_next.ovf_a    = rema_next >= dtop;
        ctl4_next.ovf_b    = remb_next >= dtop;
    end

    // Control valid bits and per-ray flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            ctl4_reg.valid <= 1'b0;
        end else if (en) begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            ctl4_reg <= ctl4_next;
        end
    end

    // Payload: advance every stage together
    always_ff @(posedge aclk) begin
        if (en) begin
            tl1_reg <= tl_i;
            pdx_reg <= dx_i * cfg_i.nx;
            pdy_reg <= dy_i * cfg_i.ny;
            pdz_reg <= dz_i * cfg_i.nz;
            pox_reg <= ox_i * cfg_i.nx;
            poy_reg <= oy_i * cfg_i.ny;
            poz_reg <= oz_i * cfg_i.nz;

            tl2_reg <= tl1_reg;
            dn2_reg <= dn_next;
            na2_reg <= na_next;
            nb2_reg <= nb_next;

            tl3_reg   <= tl2_reg;
            par3_reg  <= (dn2_reg == '0);
            nega3_reg <= na2_reg[NUMW-1] ^ dn2_reg[DOTW-1];
            negb3_reg <= nb2_reg[NUMW-1] ^ dn2_reg[DOTW-1];
            dmag3_reg <= dn2_reg[DOTW-1] ? DOTW'(-dn2_reg) : DOTW'(dn2_reg);
            amag3_reg <= na2_reg[NUMW-1] ? NUMW'(-na2_reg) : NUMW'(na2_reg);
            bmag3_reg <= nb2_reg[NUMW-1] ? NUMW'(-nb2_reg) : NUMW'(nb2_reg);

            tl4_reg   <= tl3_reg;
            den4_reg  <= dmag3_reg;
            rema4_reg <= rema_next;
            remb4_reg <= remb_next;
        end
    end

    assign ctl_o   = ctl4_reg;
    assign tl_o    = tl4_reg;
    assign den_o   = den4_reg;
    assign rem_a_o = rema4_reg;
    assign rem_b_o = remb4_reg;

endmodule

>>> src/rsi_div_cell.sv
// One restoring-division cell: resolves one quotient bit of both plane distances.
module rsi_div_cell #(
    parameter int CW   = rsi_pkg::COORD_WIDTH_DEF,
    parameter int DOTW = CW + rsi_pkg::NORM_WIDTH + 2,
    parameter int W    = DOTW + CW,
    parameter int BIT  = 0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  rsi_pkg::ctl_t        ctl_i,
    input  logic signed [CW-1:0] tl_i,
    input  logic [DOTW-1:0]      den_i,
    input  logic [W-1:0]         rem_a_i,
    input  logic [W-1:0]         rem_b_i,
    input  logic [CW-2:0]        q_a_i,
    input  logic [CW-2:0]        q_b_i,
    output rsi_pkg::ctl_t        ctl_o,
    output logic signed [CW-1:0] tl_o,
    output logic [DOTW-1:0]      den_o,
    output logic [W-1:0]         rem_a_o,
    output logic [W-1:0]         rem_b_o,
    output logic [CW-2:0]        q_a_o,
    output logic [CW-2:0]        q_b_o
);

    rsi_pkg::ctl_t        ctl_reg;
    logic signed [CW-1:0] tl_reg;
    logic [DOTW-1:0]      den_reg;
    logic [W-1:0]         rema_reg, remb_reg, rema_next, remb_next, dsh;
    logic [CW-2:0]        qa_reg, qb_reg, qa_next, qb_next;
    logic                 ga, gb;

    // Trial subtract of the shifted divisor from each remainder
    always_comb begin
        dsh       = W'(den_i) << BIT;
        ga        = rem_a_i >= dsh;
        gb        = rem_b_i >= dsh;
        rema_next = ga ? rem_a_i - dsh : rem_a_i;
        remb_next = gb ? rem_b_i - dsh : rem_b_i;
        qa_next   = q_a_i;
        qb_next   = q_b_i;
        qa_next[BIT] = ga;
        qb_next[BIT] = gb;
    end

    // Pass the valid bit and flags along
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg.valid <= 1'b0;
        end else if (en) begin
            ctl_reg <= ctl_i;
        end
    end

    // Hand the partial result to the next cell
    always_ff @(posedge aclk) begin
        if (en) begin
            tl_reg   <= tl_i;
            den_reg  <= den_i;
            rema_reg <= rema_next;
            remb_reg <= remb_next;
            qa_reg   <= qa_next;
            qb_reg   <= qb_next;
        end
    end

    assign ctl_o   = ctl_reg;
    assign tl_o    = tl_reg;
    assign den_o   = den_reg;
    assign rem_a_o = rema_reg;
    assign rem_b_o = remb_reg;
    assign q_a_o   = qa_reg;
    assign q_b_o   = qb_reg;

endmodule

>>> src/ray_slab_intersect_top.sv
// Top level of the ray and slab intersection pipeline with its configuration registers.
//
// Takes one ray per clock while no result waits on m_tready, and returns one result
// per ray, in order. A ray passes through four front stages (products, dot
// products, magnitudes, overflow test), COORD_WIDTH - 1 divider cells that each
// settle one quotient bit of both plane distances, and three stages that sign,
// order and select the hit. The pipeline moves as one: while a result waits on
// m_tready, every stage holds and s_tready is low. The configuration port is
// always ready; write it only while no ray is in flight.
module ray_slab_intersect_top #(
    parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rsi_pkg::FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // t_lower, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z from bit 0 up
    input  logic [((7*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // hit_t, surf_nx, surf_ny, surf_nz from bit 0 up
    output logic [((COORD_WIDTH+3*rsi_pkg::NORM_WIDTH+7)/8)*8-1:0] m_tdata,
    // hit_valid
    output logic                           m_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rsi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rsi_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int CW   = COORD_WIDTH;
    localparam int NW   = rsi_pkg::NORM_WIDTH;
    localparam int DOTW = CW + NW + 2;
    localparam int OFSW = rsi_pkg::PLANE_WIDTH + rsi_pkg::NORM_FRAC;
    localparam int NUMW = ((DOTW > OFSW) ? DOTW : OFSW) + 1;
    localparam int W    = ((NUMW + FRAC_BITS) > (DOTW + CW)) ? (NUMW + FRAC_BITS)
                                                              : (DOTW + CW);
    localparam int NCELL = CW - 1;
    localparam int OUTW  = ((CW + 3*NW + 7)/8)*8;
    localparam logic signed [CW-1:0] T_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] T_MIN = {1'b1, {(CW-1){1'b0}}};

    logic en;
    rsi_pkg::cfg_t cfg_reg;

    // Configuration registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.nx       <= '0;
            cfg_reg.ny       <= '0;
            cfg_reg.nz       <= NW'(1 << rsi_pkg::NORM_FRAC);
            cfg_reg.near_ofs <= '0;
            cfg_reg.far_ofs  <= rsi_pkg::PLANE_WIDTH'(1 << rsi_pkg::NORM_FRAC);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                rsi_pkg::REG_NORMAL_X:   cfg_reg.nx       <= cfg_data[NW-1:0];
                rsi_pkg::REG_NORMAL_Y:   cfg_reg.ny       <= cfg_data[NW-1:0];
                rsi_pkg::REG_NORMAL_Z:   cfg_reg.nz       <= cfg_data[NW-1:0];
                rsi_pkg::REG_PLANE_NEAR: cfg_reg.near_ofs <= cfg_data;
                rsi_pkg::REG_PLANE_FAR:  cfg_reg.far_ofs  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Whole pipeline advances while the output slot is free or being drained
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Chain links: index 0 from the front end, NCELL after the last cell
    rsi_pkg::ctl_t        ctl_c [NCELL+1];
    logic signed [CW-1:0] tl_c  [NCELL+1];
    logic [DOTW-1:0]      den_c [NCELL+1];
    logic [W-1:0]         ra_c  [NCELL+1];
    logic [W-1:0]         rb_c  [NCELL+1];
    logic [CW-2:0]        qa_c  [NCELL+1];
    logic [CW-2:0]        qb_c  [NCELL+1];

    rsi_front #(.CW(CW), .F(FRAC_BITS), .DOTW(DOTW), .NUMW(NUMW), .W(W)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .tl_i     (s_tdata[0*CW +: CW]),
        .ox_i     (s_tdata[1*CW +: CW]),
        .oy_i     (s_tdata[2*CW +: CW]),
        .oz_i     (s_tdata[3*CW +: CW]),
        .dx_i     (s_tdata[4*CW +: CW]),
        .dy_i     (s_tdata[5*CW +: CW]),
        .dz_i     (s_tdata[6*CW +: CW]),
        .cfg_i    (cfg_reg),
        .ctl_o    (ctl_c[0]),
        .tl_o     (tl_c[0]),
        .den_o    (den_c[0]),
        .rem_a_o  (ra_c[0]),
        .rem_b_o  (rb_c[0])
    );

    assign qa_c[0] = '0;
    assign qb_c[0] = '0;

    // Divider chain, most significant quotient bit first
    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        rsi_div_cell #(.CW(CW), .DOTW(DOTW), .W(W), .BIT(NCELL-1-k)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .ctl_i   (ctl_c[k]),
            .tl_i    (tl_c[k]),
            .den_i   (den_c[k]),
            .rem_a_i (ra_c[k]),
            .rem_b_i (rb_c[k]),
            .q_a_i   (qa_c[k]),
            .q_b_i   (qb_c[k]),
            .ctl_o   (ctl_c[k+1]),
            .tl_o    (tl_c[k+1]),
            .den_o   (den_c[k+1]),
            .rem_a_o (ra_c[k+1]),
            .rem_b_o (rb_c[k+1]),
            .q_a_o   (qa_c[k+1]),
            .q_b_o   (qb_c[k+1])
        );
    end

    // Tail stage 1: apply sign and saturation
    logic                 v1_reg, par1_reg;
    logic signed [CW-1:0] tl1_reg, ta1_reg, tb1_reg, ta_next, tb_next, qa_ext, qb_ext;
    rsi_pkg::ctl_t        ctl_end;

    always_comb begin
        ctl_end = ctl_c[NCELL];
        qa_ext  = {1'b0, qa_c[NCELL]};
        qb_ext  = {1'b0, qb_c[NCELL]};
        if (ctl_end.ovf_a) ta_next = ctl_end.neg_a ? T_MIN : T_MAX;
        else               ta_next = ctl_end.neg_a ? -qa_ext : qa_ext;
        if (ctl_end.ovf_b) tb_next = ctl_end.neg_b ? T_MIN : T_MAX;
        else               tb_next = ctl_end.neg_b ? -qb_ext : qb_ext;
    end

    // Tail stage 2: order the two distances
    logic                 v2_reg, par2_reg;
    logic signed [CW-1:0] tl2_reg, tn2_reg, tf2_reg, tb2_reg;

    // Tail stage 3: pick the hit and its normal
    logic                 hit_next, far_next, hit_reg;
    logic signed [CW-1:0] tc_next, t_reg;
    logic signed [NW-1:0] nx_reg, ny_reg, nz_reg, nx_next, ny_next, nz_next;
    logic                 m_tvalid_reg;

    always_comb begin
        hit_next = 1'b0;
        tc_next  = '0;
        if (!par2_reg) begin
            priority if (tn2_reg > tl2_reg) begin
                hit_next = 1'b1;
                tc_next  = tn2_reg;
            end else if (tf2_reg > tl2_reg) begin
                hit_next = 1'b1;
                tc_next  = tf2_reg;
            end
        end
        far_next = (tc_next == tb2_reg);
        nx_next  = '0;
        ny_next  = '0;
        nz_next  = '0;
        if (hit_next) begin
            nx_next = far_next ? cfg_reg.nx : -cfg_reg.nx;
            ny_next = far_next ? cfg_reg.ny : -cfg_reg.ny;
            nz_next = far_next ? cfg_reg.nz : -cfg_reg.nz;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            v1_reg       <= ctl_end.valid;
            v2_reg       <= v1_reg;
            m_tvalid_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            par1_reg <= ctl_end.parallel;
            tl1_reg  <= tl_c[NCELL];
            ta1_reg  <= ta_next;
            tb1_reg  <= tb_next;

            par2_reg <= par1_reg;
            tl2_reg  <= tl1_reg;
            tn2_reg  <= (ta1_reg < tb1_reg) ? ta1_reg : tb1_reg;
            tf2_reg  <= (ta1_reg < tb1_reg) ? tb1_reg : ta1_reg;
            tb2_reg  <= tb1_reg;

            hit_reg <= hit_next;
            t_reg   <= tc_next;
            nx_reg  <= nx_next;
            ny_reg  <= ny_next;
            nz_reg  <= nz_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = hit_reg;
    assign m_tdata  = OUTW'({nz_reg, ny_reg, nx_reg, t_reg});

`ifndef SYNTHESIS
    // A result with no hit carries all-zero data
    a_nohit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("no-hit result with nonzero data");

    // A waiting result blocks new rays
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while output stalled");

    // Reset empties the output slot
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");
`endif

endmodule
